// File: src/playfair_digraph_decrypt_defines.svh
// ----------------------------------------------------------------------------
// Playfair digraph decrypt assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_DEFINES_SVH

// same-cycle implication
`define PFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and payload types of the Playfair digraph decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

	localparam int GRID_SIZE = 5;
	localparam int KEY_W     = 8 * GRID_SIZE;
	localparam int CFG_IDX_W = 3;

	// reset square MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
	localparam logic [KEY_W-1:0] KEY_RESET [GRID_SIZE] = '{
		40'd331891624267,
		40'd366386040913,
		40'd387995621465,
		40'd297632092743,
		40'd293455807043
	};

	typedef struct packed {
		logic [7:0] first_cipher;
		logic [7:0] second_cipher;
	} cipher_t;

	typedef struct packed {
		logic [7:0] first_plain;
		logic [7:0] second_plain;
		logic       letter_missing;
	} plain_t;

endpackage

`default_nettype wire

// File: src/pfd_locate.sv
// ----------------------------------------------------------------------------
// pfd_locate
// One lane: folds a byte to uppercase and finds its first cell in the square.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_locate #(
	parameter int GRID_SIZE = pfd_pkg::GRID_SIZE
) (
	input  logic [GRID_SIZE-1:0][8*GRID_SIZE-1:0] key,
	input  logic [7:0]                            letter,
	output logic [7:0]                            folded,
	output logic                                  found,
	output logic [$clog2(GRID_SIZE)-1:0]          row,
	output logic [$clog2(GRID_SIZE)-1:0]          col
);
	localparam int IdxW = $clog2(GRID_SIZE);

	assign folded = (letter >= 8'h61 && letter <= 8'h7a) ? letter - 8'd32 : letter;

	// scan backwards so the first row-major match wins
	always_comb begin
		found = 1'b0;
		row   = '0;
		col   = '0;
		for (int r = GRID_SIZE - 1; r >= 0; r--) begin
			for (int c = GRID_SIZE - 1; c >= 0; c--) begin
				if (key[r][8*(GRID_SIZE-1-c) +: 8] == folded) begin
					found = 1'b1;
					row   = r[IdxW-1:0];
					col   = c[IdxW-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/pfd_merge.sv
// ----------------------------------------------------------------------------
// pfd_merge
// Combines both lane positions: row, column or rectangle rule, then lookup; unmatched pairs pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_merge #(
	parameter int GRID_SIZE = pfd_pkg::GRID_SIZE
) (
	input  logic [GRID_SIZE-1:0][8*GRID_SIZE-1:0] key,
	input  logic [7:0]                            letter_a,
	input  logic                                  found_a,
	input  logic [$clog2(GRID_SIZE)-1:0]          row_a,
	input  logic [$clog2(GRID_SIZE)-1:0]          col_a,
	input  logic [7:0]                            letter_b,
	input  logic                                  found_b,
	input  logic [$clog2(GRID_SIZE)-1:0]          row_b,
	input  logic [$clog2(GRID_SIZE)-1:0]          col_b,
	output pfd_pkg::plain_t                       plain
);
	import pfd_pkg::*;

	localparam int IdxW = $clog2(GRID_SIZE);

	logic [7:0]      cell_v [GRID_SIZE][GRID_SIZE];
	logic [IdxW-1:0] ra, ca, rb, cb;

	for (genvar r = 0; r < GRID_SIZE; r++) begin : g_row
		for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
			assign cell_v[r][c] = key[r][8*(GRID_SIZE-1-c) +: 8];
		end
	end

	function automatic logic [IdxW-1:0] step_back(input logic [IdxW-1:0] x);
		return (x == '0) ? IdxW'(GRID_SIZE - 1) : x - 1'b1;
	endfunction

	always_comb begin
		ra = row_a;
		ca = col_a;
		rb = row_b;
		cb = col_b;
		if (row_a == row_b) begin
			ca = step_back(col_a);
			cb = step_back(col_b);
		end else if (col_a == col_b) begin
			ra = step_back(row_a);
			rb = step_back(row_b);
		end else begin
			ca = col_b;
			cb = col_a;
		end
	end

	always_comb begin
		if (found_a && found_b) begin
			plain.first_plain    = cell_v[ra][ca];
			plain.second_plain   = cell_v[rb][cb];
			plain.letter_missing = 1'b0;
		end else begin
			plain.first_plain    = letter_a;
			plain.second_plain   = letter_b;
			plain.letter_missing = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/playfair_digraph_decrypt.sv
// Path: lane stage register, then merge stage register driving plain_valid.
// Throughput: one digraph per cycle; the two-stage pipeline advances whenever
// its output register is empty or being drained.
// Reset: arst_n clears both stage valids and loads the default key square
// MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC.
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt
// Two locate lanes search the key square in parallel; a merge stage applies
// the Playfair decryption rules and fills the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_decrypt #(
	parameter int GRID_SIZE = pfd_pkg::GRID_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [8*GRID_SIZE-1:0]          cfg_data,
	input  logic                            cipher_valid,
	output logic                            cipher_ready,
	input  pfd_pkg::cipher_t                cipher,
	output logic                            plain_valid,
	input  logic                            plain_ready,
	output pfd_pkg::plain_t                 plain
);
	import pfd_pkg::*;

	`include "playfair_digraph_decrypt_defines.svh"

	localparam int IdxW = $clog2(GRID_SIZE);
	localparam int KeyW = 8 * GRID_SIZE;

	logic [GRID_SIZE-1:0][KeyW-1:0] key_q;

	logic [7:0]      fold_a, fold_b;
	logic            hit_a, hit_b;
	logic [IdxW-1:0] row_a, col_a, row_b, col_b;

	logic            valid_s1;
	logic [7:0]      letter_a_s1, letter_b_s1;
	logic            found_a_s1, found_b_s1;
	logic [IdxW-1:0] row_a_s1, col_a_s1, row_b_s1, col_b_s1;

	logic            valid_s2;
	plain_t          plain_s2;
	plain_t          merged;

	logic            adv_s2, adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_SIZE; i++) begin
				key_q[i] <= KEY_RESET[i][KeyW-1:0];
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < GRID_SIZE; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					key_q[i] <= cfg_data;
				end
			end
		end
	end

	pfd_locate #(.GRID_SIZE(GRID_SIZE)) u_lane_a (
		.key    (key_q),
		.letter (cipher.first_cipher),
		.folded (fold_a),
		.found  (hit_a),
		.row    (row_a),
		.col    (col_a)
	);

	pfd_locate #(.GRID_SIZE(GRID_SIZE)) u_lane_b (
		.key    (key_q),
		.letter (cipher.second_cipher),
		.folded (fold_b),
		.found  (hit_b),
		.row    (row_b),
		.col    (col_b)
	);

	assign adv_s2       = !valid_s2 || plain_ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign cipher_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= cipher_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cipher_valid) begin
			letter_a_s1 <= fold_a;
			letter_b_s1 <= fold_b;
			found_a_s1  <= hit_a;
			found_b_s1  <= hit_b;
			row_a_s1    <= row_a;
			col_a_s1    <= col_a;
			row_b_s1    <= row_b;
			col_b_s1    <= col_b;
		end
	end

	pfd_merge #(.GRID_SIZE(GRID_SIZE)) u_merge (
		.key      (key_q),
		.letter_a (letter_a_s1),
		.found_a  (found_a_s1),
		.row_a    (row_a_s1),
		.col_a    (col_a_s1),
		.letter_b (letter_b_s1),
		.found_b  (found_b_s1),
		.row_b    (row_b_s1),
		.col_b    (col_b_s1),
		.plain    (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			plain_s2 <= merged;
		end
	end

	assign plain_valid = valid_s2;
	assign plain       = plain_s2;

	`PFD_ASSERT_NEXT(a_in_to_s1, cipher_valid && cipher_ready, valid_s1, "transfer lost at stage 1")
	`PFD_ASSERT_NOW(a_rose_from_s1, $rose(valid_s2), $past(valid_s1), "result without stage 1 item")
	`PFD_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s2, valid_s1 && $stable(letter_a_s1), "stage 1 dropped")
	`PFD_ASSERT_NOW(a_missing_pass, valid_s1 && !(found_a_s1 && found_b_s1),
		merged.letter_missing && merged.first_plain == letter_a_s1, "missing letter not passed")

endmodule

`default_nettype wire

// File: tb/playfair_digraph_decrypt_checker.sv
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_checker
// Watches the key, cipher and plain channels of the Playfair decryptor. It
// keeps its own copy of the key square and decrypts each accepted digraph
// into a queue of expected plaintext. Each plain transfer is compared field
// by field with the oldest entry in that queue.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_decrypt_checker
	import pfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	input  logic                 cipher_valid,
	input  logic                 cipher_ready,
	input  cipher_t              cipher,
	input  logic                 plain_valid,
	input  logic                 plain_ready,
	input  plain_t               plain,
	output int                   outstanding,
	output int                   failures
);

	logic [KEY_W-1:0] key_sq [GRID_SIZE];
	plain_t           expected_plain [$];
	plain_t           oldest;
	int               fail_tally;

	function automatic logic [7:0] square_at(int r, int c);
		return key_sq[r][8*(GRID_SIZE-1-c) +: 8];
	endfunction

	function automatic logic [7:0] upper(logic [7:0] b);
		if (b >= "a" && b <= "z") begin
			return b - 8'd32;
		end
		return b;
	endfunction

	// first match in row-major order wins
	function automatic bit find_cell(logic [7:0] b, output int r, output int c);
		bit hit;
		hit = 1'b0;
		r = 0;
		c = 0;
		for (int i = 0; i < GRID_SIZE; i++) begin
			for (int j = 0; j < GRID_SIZE; j++) begin
				if (!hit && square_at(i, j) == b) begin
					hit = 1'b1;
					r = i;
					c = j;
				end
			end
		end
		return hit;
	endfunction

	function automatic plain_t decrypt_digraph(cipher_t ct);
		plain_t     p;
		logic [7:0] a, b;
		int         r1, c1, r2, c2;
		bit         found_a, found_b;
		a = upper(ct.first_cipher);
		b = upper(ct.second_cipher);
		found_a = find_cell(a, r1, c1);
		found_b = find_cell(b, r2, c2);
		p.letter_missing = 1'b0;
		if (!found_a || !found_b) begin
			p.first_plain    = a;
			p.second_plain   = b;
			p.letter_missing = 1'b1;
		end else if (r1 == r2) begin
			p.first_plain  = square_at(r1, (c1 + GRID_SIZE - 1) % GRID_SIZE);
			p.second_plain = square_at(r2, (c2 + GRID_SIZE - 1) % GRID_SIZE);
		end else if (c1 == c2) begin
			p.first_plain  = square_at((r1 + GRID_SIZE - 1) % GRID_SIZE, c1);
			p.second_plain = square_at((r2 + GRID_SIZE - 1) % GRID_SIZE, c2);
		end else begin
			p.first_plain  = square_at(r1, c2);
			p.second_plain = square_at(r2, c1);
		end
		return p;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", field, want_v, got_v);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sq = KEY_RESET;
			expected_plain.delete();
			fail_tally = 0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < GRID_SIZE) begin
				key_sq[cfg_index] = cfg_data;
			end
			if (cipher_valid && cipher_ready) begin
				expected_plain.push_back(decrypt_digraph(cipher));
			end
			if (plain_valid && plain_ready) begin
				if (expected_plain.size() == 0) begin
					$error("plain transfer with no digraph pending: %0h", plain);
					fail_tally++;
				end else begin
					oldest = expected_plain.pop_front();
					check_field("first_plain", oldest.first_plain, plain.first_plain);
					check_field("second_plain", oldest.second_plain, plain.second_plain);
					check_field("letter_missing", 8'(oldest.letter_missing),
						8'(plain.letter_missing));
				end
			end
			outstanding <= expected_plain.size();
			failures <= fail_tally;
		end
	end

endmodule

`default_nettype wire

// File: tb/playfair_digraph_decrypt_test.sv
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_test
// Drives digraphs and key square writes into the Playfair decryptor under
// random back-pressure. The key squares used are the default square,
// shuffled alphabets, squares with repeated and non-letter bytes, and
// all-zero and all-one squares. A checker module beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_decrypt_test;
	import pfd_pkg::*;

	localparam int LATENCY   = 2;
	localparam int PHASES    = 10;
	localparam int HOLD_LONG = 120;
	localparam int IDLE_MAX  = 1000;
	localparam int HOLD_PH   = 6;

	localparam logic [15:0] DIRECTED_PAIRS [22] = '{
		"MK", "KM", "EE", "MU", "KC", "CK", "DC", "MN", "QD", "mk", "Az",
		"ZA", "JA", "AJ", "  ", 16'h0000, 16'hFFFF, 16'h7F80, 16'h405B,
		16'h607B, "az", "Hh"
	};

	localparam logic [7:0] MIXED_BYTES [8] = '{
		"A", "B", "C", "D", "E", 8'h00, 8'hFF, "a"
	};

	typedef enum int {SQ_DEFAULT, SQ_SHUFFLED, SQ_MIXED, SQ_ZERO, SQ_ONES} square_kind_e;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [KEY_W-1:0]     cfg_data     = '0;
	logic                 cipher_valid = 1'b0;
	logic                 cipher_ready;
	cipher_t              cipher       = '0;
	logic                 plain_valid;
	logic                 plain_ready  = 1'b0;
	plain_t               plain;

	int                   outstanding;
	int                   failures;
	logic [KEY_W-1:0]     sq_rows [GRID_SIZE];
	bit                   calm         = 1'b0;
	bit                   hold_req     = 1'b0;
	int                   digraphs_sent;
	int                   squares_loaded;

	playfair_digraph_decrypt u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cipher_valid (cipher_valid),
		.cipher_ready (cipher_ready),
		.cipher       (cipher),
		.plain_valid  (plain_valid),
		.plain_ready  (plain_ready),
		.plain        (plain)
	);

	playfair_digraph_decrypt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cipher_valid (cipher_valid),
		.cipher_ready (cipher_ready),
		.cipher       (cipher),
		.plain_valid  (plain_valid),
		.plain_ready  (plain_ready),
		.plain        (plain),
		.outstanding  (outstanding),
		.failures     (failures)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] cell_byte(int r, int c);
		return sq_rows[r][8*(GRID_SIZE-1-c) +: 8];
	endfunction

	function automatic logic [7:0] maybe_lower(logic [7:0] b);
		if (b >= "A" && b <= "Z" && $urandom_range(0, 3) == 0) begin
			return b | 8'h20;
		end
		return b;
	endfunction

	// mostly letters from the square, biased toward shared rows and columns
	function automatic cipher_t random_digraph();
		int         r1, c1, r2, c2, mode;
		logic [7:0] a, b;
		r1 = $urandom_range(0, GRID_SIZE - 1);
		c1 = $urandom_range(0, GRID_SIZE - 1);
		r2 = $urandom_range(0, GRID_SIZE - 1);
		c2 = $urandom_range(0, GRID_SIZE - 1);
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1: begin
				r2 = r1;
			end
			2, 3: begin
				c2 = c1;
			end
			4: begin
				r2 = r1;
				c2 = c1;
			end
			default: begin
			end
		endcase
		a = maybe_lower(cell_byte(r1, c1));
		b = maybe_lower(cell_byte(r2, c2));
		if (mode == 8) begin
			b = 8'($urandom_range(0, 255));
		end
		if (mode == 9) begin
			a = 8'($urandom_range(0, 255));
		end
		return cipher_t'({a, b});
	endfunction

	task automatic build_square(input square_kind_e kind);
		logic [7:0] pool [26];
		logic [7:0] t;
		int         drop, j;
		for (int k = 0; k < 26; k++) begin
			pool[k] = 8'("A" + k);
		end
		drop = ($urandom_range(0, 1) == 0) ? ("J" - "A") : $urandom_range(0, 25);
		pool[drop] = pool[25];
		for (int k = GRID_SIZE * GRID_SIZE - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = pool[k];
			pool[k] = pool[j];
			pool[j] = t;
		end
		for (int r = 0; r < GRID_SIZE; r++) begin
			for (int c = 0; c < GRID_SIZE; c++) begin
				case (kind)
					SQ_MIXED: t = MIXED_BYTES[$urandom_range(0, 7)];
					SQ_ZERO:  t = 8'h00;
					SQ_ONES:  t = 8'hFF;
					default:  t = pool[r * GRID_SIZE + c];
				endcase
				sq_rows[r][8*(GRID_SIZE-1-c) +: 8] = t;
			end
		end
	endtask

	task automatic write_key_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [KEY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic send_digraph(input cipher_t ct);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cipher_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		cipher_valid <= 1'b1;
		cipher <= ct;
		do @(posedge clk); while (!cipher_ready);
		digraphs_sent++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				plain_ready <= 1'b0;
				repeat (HOLD_LONG) @(posedge clk);
				hold_req <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				plain_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			plain_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < IDLE_MAX) begin
			@(posedge clk);
			if ((cipher_valid && cipher_ready) || (plain_valid && plain_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("timeout: no transfer for %0d cycles", IDLE_MAX);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		square_kind_e kind;
		int           n_items;
		sq_rows = KEY_RESET;
		digraphs_sent = 0;
		squares_loaded = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       kind = SQ_DEFAULT;
				2:       kind = SQ_MIXED;
				3:       kind = SQ_ZERO;
				4:       kind = SQ_ONES;
				default: kind = SQ_SHUFFLED;
			endcase
			if (kind == SQ_ZERO || kind == SQ_ONES) begin
				n_items = 60;
			end else if (ph == PHASES - 1) begin
				n_items = 250;
			end else begin
				n_items = (ph == 0) ? 150 : 170;
			end
			if (ph > 0) begin
				wait_drained();
				build_square(kind);
				for (int r = 0; r < GRID_SIZE; r++) begin
					write_key_row(CFG_IDX_W'(r), sq_rows[r]);
				end
				if (kind == SQ_MIXED) begin
					write_key_row(CFG_IDX_W'($urandom_range(GRID_SIZE, 2**CFG_IDX_W - 1)),
						KEY_W'({$urandom(), $urandom()}));
				end
				cfg_valid <= 1'b0;
				squares_loaded++;
			end
			if (ph == PHASES - 1) begin
				calm = 1'b1;
			end
			if (ph == HOLD_PH) begin
				hold_req <= 1'b1;
			end
			if (ph == 0) begin
				foreach (DIRECTED_PAIRS[i]) begin
					send_digraph(cipher_t'(DIRECTED_PAIRS[i]));
				end
			end
			for (int i = 0; i < n_items; i++) begin
				send_digraph(random_digraph());
			end
			cipher_valid <= 1'b0;
		end
		wait_drained();
		repeat (LATENCY + 2) @(posedge clk);
		$display("%0d digraphs decrypted under %0d key squares: default, shuffled,",
			digraphs_sent, squares_loaded);
		$display("repeated and non-letter bytes, all-zero and all-one, with back-pressure.");
		if (failures == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/pfd_pkg.sv
src/pfd_locate.sv
src/pfd_merge.sv
src/playfair_digraph_decrypt.sv
tb/playfair_digraph_decrypt_checker.sv
tb/playfair_digraph_decrypt_test.sv
